### rtl/icmp_session_handshake_core_macros.svh
// Assertion helpers for the handshake core.
`ifndef ICMP_SESSION_HANDSHAKE_CORE_MACROS_SVH
`define ICMP_SESSION_HANDSHAKE_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ICMP_SH_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ICMP_SH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/icmp_sh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_sh_pkg
// Types, codes and helpers shared by the handshake core modules.
// ----------------------------------------------------------------------------
package icmp_sh_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_LISTENER_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PEER_ADDRESS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_SECONDS = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_VERIFY_LIMIT = 2'd3;

  localparam logic [1:0] OP_SERVICE = 2'd0;
  localparam logic [1:0] OP_ESTABLISH = 2'd1;
  localparam logic [1:0] OP_VERIFY = 2'd2;

  localparam logic KIND_ESTABLISH = 1'b0;
  localparam logic KIND_VERIFY = 1'b1;

  localparam logic [7:0] TIMEOUT_RESET = 8'd3;
  localparam logic [7:0] VERIFY_LIMIT_RESET = 8'd11;
  localparam logic [7:0] STEP_MAX = 8'd255;
  localparam logic [7:0] STEP_INC_CLIENT = 8'd1;
  localparam logic [7:0] STEP_INC_LISTENER = 8'd2;

  localparam int unsigned InTdataW = 80;
  localparam int unsigned OutTdataW = 112;

  typedef struct packed {
    logic        listener_mode;
    logic [31:0] peer_address;
    logic [7:0]  timeout_seconds;
    logic [7:0]  verify_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        new_second;
    logic [15:0] fresh_id;
    logic [31:0] sender_address;
    logic [15:0] message_id;
    logic [7:0]  message_step;
  } item_t;

  typedef struct packed {
    logic        send_valid;
    logic        send_kind;
    logic [15:0] send_id;
    logic [7:0]  send_step;
    logic [31:0] send_address;
    logic        done_res;
    logic [15:0] done_id;
    logic [31:0] done_address;
  } result_t;

  // min(local, received) + inc, saturating at 255
  function automatic logic [7:0] next_step(logic [7:0] local_step, logic [7:0] rx_step,
                                           logic [7:0] inc);
    logic [7:0] m;
    logic [8:0] sum;
    m = (local_step < rx_step) ? local_step : rx_step;
    sum = {1'b0, m} + {1'b0, inc};
    return sum[8] ? STEP_MAX : sum[7:0];
  endfunction

endpackage

### rtl/icmp_sh_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_sh_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module icmp_sh_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [icmp_sh_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [icmp_sh_pkg::CfgDataW-1:0]   cfg_data,
  output icmp_sh_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.listener_mode <= 1'b0;
      cfg.peer_address <= '0;
      cfg.timeout_seconds <= icmp_sh_pkg::TIMEOUT_RESET;
      cfg.verify_limit <= icmp_sh_pkg::VERIFY_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        icmp_sh_pkg::CFG_LISTENER_MODE:   cfg.listener_mode <= cfg_data[0];
        icmp_sh_pkg::CFG_PEER_ADDRESS:    cfg.peer_address <= cfg_data[31:0];
        icmp_sh_pkg::CFG_TIMEOUT_SECONDS: cfg.timeout_seconds <= cfg_data[7:0];
        icmp_sh_pkg::CFG_VERIFY_LIMIT:    cfg.verify_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/icmp_sh_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_sh_engine
// Session state registers and the single-pass update for one word.
// ----------------------------------------------------------------------------
module icmp_sh_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  icmp_sh_pkg::cfg_t    cfg,
  input  icmp_sh_pkg::item_t   item,
  input  logic                 fire,
  output icmp_sh_pkg::result_t res
);

  logic [7:0]  step_counter, step_counter_next;
  logic [7:0]  seconds_since_verify, seconds_since_verify_next;
  logic [15:0] session_id, session_id_next;
  logic [31:0] learned_address, learned_address_next;

  logic [7:0] sec_inc;
  logic [7:0] step_svc;
  logic [7:0] sec_svc;
  logic       est_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_counter <= '0;
      seconds_since_verify <= '0;
      session_id <= '0;
      learned_address <= '0;
    end else if (fire) begin
      step_counter <= step_counter_next;
      seconds_since_verify <= seconds_since_verify_next;
      session_id <= session_id_next;
      learned_address <= learned_address_next;
    end
  end

  always_comb begin
    step_counter_next = step_counter;
    seconds_since_verify_next = seconds_since_verify;
    session_id_next = session_id;
    learned_address_next = learned_address;
    res = '0;

    // service pass: saturating second count, then timeout restart
    sec_inc = (item.new_second && seconds_since_verify != icmp_sh_pkg::STEP_MAX)
            ? seconds_since_verify + 8'd1 : seconds_since_verify;
    if (sec_inc > cfg.timeout_seconds) begin
      step_svc = '0;
      sec_svc = '0;
    end else begin
      step_svc = step_counter;
      sec_svc = sec_inc;
    end

    est_ok = (step_counter == 8'd0) ||
             (item.sender_address == learned_address && item.message_id == session_id);

    unique case (item.op)
      icmp_sh_pkg::OP_SERVICE: begin
        step_counter_next = step_svc;
        seconds_since_verify_next = sec_svc;
        if (!cfg.listener_mode) begin
          if (step_svc == 8'd0) session_id_next = item.fresh_id;
          // even step still in range: send the next establish
          if (!step_svc[0] && step_svc <= cfg.verify_limit) begin
            seconds_since_verify_next = '0;
            step_counter_next = step_svc + 8'd1;
            res.send_valid = 1'b1;
            res.send_kind = icmp_sh_pkg::KIND_ESTABLISH;
            res.send_id = session_id_next;
            res.send_step = step_svc + 8'd1;
            res.send_address = cfg.peer_address;
          end
        end
      end
      icmp_sh_pkg::OP_ESTABLISH: begin
        if (cfg.listener_mode && est_ok) begin
          if (step_counter == 8'd0) begin
            learned_address_next = item.sender_address;
            session_id_next = item.message_id;
          end
          seconds_since_verify_next = '0;
          step_counter_next = icmp_sh_pkg::next_step(step_counter, item.message_step,
                                                     icmp_sh_pkg::STEP_INC_LISTENER);
          res.send_valid = 1'b1;
          res.send_kind = icmp_sh_pkg::KIND_VERIFY;
          res.send_id = item.message_id;
          res.send_step = step_counter_next;
          res.send_address = learned_address_next;
        end
      end
      icmp_sh_pkg::OP_VERIFY: begin
        if (!cfg.listener_mode && item.sender_address == cfg.peer_address &&
            item.message_id == session_id) begin
          step_counter_next = icmp_sh_pkg::next_step(step_counter, item.message_step,
                                                     icmp_sh_pkg::STEP_INC_CLIENT);
          seconds_since_verify_next = '0;
        end
      end
      default: ;
    endcase

    res.done_res = step_counter_next > cfg.verify_limit;
    if (res.done_res) begin
      res.done_id = session_id_next;
      res.done_address = cfg.listener_mode ? learned_address_next : cfg.peer_address;
    end
  end

endmodule

### rtl/icmp_session_handshake_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_session_handshake_core
// Two-role session handshake engine with stream ports and a config port.
// ----------------------------------------------------------------------------
// One word is accepted per clock while the output is not stalled and yields
// exactly one result word: an input register, then the combinational session
// state update, then the result register. The state registers load together
// with the result register, so sustained rate is one word per cycle.
// Configuration writes are expected only while no word is in flight.
`include "icmp_session_handshake_core_macros.svh"

module icmp_session_handshake_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [icmp_sh_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [icmp_sh_pkg::CfgDataW-1:0]     cfg_data,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // new_second[0], fresh_id[16:1], sender_address[48:17], message_id[64:49],
  // message_step[72:65], zero pad [79:73]
  input  logic [icmp_sh_pkg::InTdataW-1:0]     s_axis_tdata,
  // op[1:0]
  input  logic [1:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // send_valid[0], send_id[16:1], send_step[24:17], send_address[56:25],
  // done_res[57], done_id[73:58], done_address[105:74], zero pad [111:106]
  output logic [icmp_sh_pkg::OutTdataW-1:0]    m_axis_tdata,
  // send_kind[0]
  output logic [0:0]                           m_axis_tuser
);

  icmp_sh_pkg::cfg_t    cfg;
  icmp_sh_pkg::item_t   in_item;
  icmp_sh_pkg::result_t res;
  icmp_sh_pkg::result_t out_res;
  logic                 in_valid;
  logic                 out_valid;
  logic                 move;

  icmp_sh_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // word advances from input register to result register
  assign move = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.op <= s_axis_tuser;
      in_item.new_second <= s_axis_tdata[0];
      in_item.fresh_id <= s_axis_tdata[16:1];
      in_item.sender_address <= s_axis_tdata[48:17];
      in_item.message_id <= s_axis_tdata[64:49];
      in_item.message_step <= s_axis_tdata[72:65];
    end
  end

  icmp_sh_engine u_engine (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .item(in_item),
    .fire(move),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser = out_res.send_kind;
  assign m_axis_tdata = {6'd0, out_res.done_address, out_res.done_id, out_res.done_res,
                         out_res.send_address, out_res.send_step, out_res.send_id,
                         out_res.send_valid};

  `ICMP_SH_ASSERT_IMPL(a_send_step_nonzero, clk, rst, m_axis_tvalid && out_res.send_valid, out_res.send_step != 8'd0, "sent message carries step zero")
  `ICMP_SH_ASSERT_IMPL(a_verify_only_listener, clk, rst, m_axis_tvalid && out_res.send_valid && out_res.send_kind, cfg.listener_mode, "verify sent outside listener role")
  `ICMP_SH_ASSERT_NEXT(a_in_reg_holds, clk, rst, in_valid && !move, in_valid && $stable(in_item), "pending word lost from input register")

endmodule

### tb/icmp_session_handshake_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_session_handshake_checker
// Watches the config port and both streams of the handshake core, keeps its
// own copy of the session state, and compares every result word in order.
// ----------------------------------------------------------------------------
module icmp_session_handshake_checker
  import icmp_sh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CfgIdxW-1:0]    cfg_index,
  input  logic [CfgDataW-1:0]   cfg_data,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [InTdataW-1:0]   s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OutTdataW-1:0]  m_axis_tdata,
  input  logic [0:0]            m_axis_tuser,
  output int unsigned           failures,
  output int unsigned           pending,
  output int unsigned           results_checked,
  output int unsigned           dones_seen
);

  cfg_t        regs;
  logic [7:0]  step;
  logic [7:0]  secs;
  logic [15:0] sid;
  logic [31:0] learned;
  result_t     replies_due[$];

  int unsigned miss_count = 0;
  int unsigned checked = 0;
  int unsigned done_count = 0;

  // lower of local and received step, plus inc, clamped at 255
  function automatic logic [7:0] step_after(input logic [7:0] rx, input logic [7:0] inc);
    logic [8:0] total;
    total = {1'b0, ((step < rx) ? step : rx)} + {1'b0, inc};
    return (total > 9'd255) ? 8'hFF : total[7:0];
  endfunction

  task automatic advance_session(input item_t w, output result_t r);
    r = '0;
    case (w.op)
      OP_SERVICE: begin
        if (w.new_second && secs != 8'hFF) secs = secs + 8'd1;
        if (secs > regs.timeout_seconds) begin
          step = 8'd0;
          secs = 8'd0;
        end
        if (!regs.listener_mode) begin
          if (step == 8'd0) sid = w.fresh_id;
          if (!step[0] && step <= regs.verify_limit) begin
            secs = 8'd0;
            step = step + 8'd1;
            r.send_valid   = 1'b1;
            r.send_kind    = KIND_ESTABLISH;
            r.send_id      = sid;
            r.send_step    = step;
            r.send_address = regs.peer_address;
          end
        end
      end
      OP_ESTABLISH: begin
        if (regs.listener_mode &&
            (step == 8'd0 || (w.sender_address == learned && w.message_id == sid))) begin
          // first contact pins the peer and the session id
          if (step == 8'd0) begin
            learned = w.sender_address;
            sid = w.message_id;
          end
          secs = 8'd0;
          step = step_after(w.message_step, STEP_INC_LISTENER);
          r.send_valid   = 1'b1;
          r.send_kind    = KIND_VERIFY;
          r.send_id      = w.message_id;
          r.send_step    = step;
          r.send_address = learned;
        end
      end
      OP_VERIFY: begin
        if (!regs.listener_mode && w.sender_address == regs.peer_address &&
            w.message_id == sid) begin
          step = step_after(w.message_step, STEP_INC_CLIENT);
          secs = 8'd0;
        end
      end
      default: ;
    endcase
    if (step > regs.verify_limit) begin
      r.done_res     = 1'b1;
      r.done_id      = sid;
      r.done_address = regs.listener_mode ? learned : regs.peer_address;
    end
  endtask

  task automatic note_mismatch(input string why, input result_t want, input result_t got);
    miss_count++;
    if (miss_count <= 10) begin
      $display("%0t %s", $realtime, why);
      $display("  exp: sv %0d kind %0d id %h step %0d addr %h | done %0d id %h addr %h",
               want.send_valid, want.send_kind, want.send_id, want.send_step,
               want.send_address, want.done_res, want.done_id, want.done_address);
      $display("  got: sv %0d kind %0d id %h step %0d addr %h | done %0d id %h addr %h",
               got.send_valid, got.send_kind, got.send_id, got.send_step,
               got.send_address, got.done_res, got.done_id, got.done_address);
    end
  endtask

  always @(posedge clk) begin
    item_t   w;
    result_t want;
    result_t got;
    if (rst) begin
      regs.listener_mode   = 1'b0;
      regs.peer_address    = 32'd0;
      regs.timeout_seconds = TIMEOUT_RESET;
      regs.verify_limit    = VERIFY_LIMIT_RESET;
      step = 8'd0;
      secs = 8'd0;
      sid = 16'd0;
      learned = 32'd0;
      replies_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LISTENER_MODE:   regs.listener_mode = cfg_data[0];
          CFG_PEER_ADDRESS:    regs.peer_address = cfg_data[31:0];
          CFG_TIMEOUT_SECONDS: regs.timeout_seconds = cfg_data[7:0];
          CFG_VERIFY_LIMIT:    regs.verify_limit = cfg_data[7:0];
          default: ;
        endcase
      end
      // result side first: a word leaving now belongs to an earlier input
      if (m_axis_tvalid && m_axis_tready) begin
        got.send_valid   = m_axis_tdata[0];
        got.send_kind    = m_axis_tuser[0];
        got.send_id      = m_axis_tdata[16:1];
        got.send_step    = m_axis_tdata[24:17];
        got.send_address = m_axis_tdata[56:25];
        got.done_res     = m_axis_tdata[57];
        got.done_id      = m_axis_tdata[73:58];
        got.done_address = m_axis_tdata[105:74];
        checked++;
        if (got.done_res) done_count++;
        if (replies_due.size() == 0) begin
          note_mismatch("result word with nothing outstanding", '0, got);
        end else begin
          want = replies_due.pop_front();
          if (got !== want) note_mismatch("result word mismatch", want, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        w.op             = s_axis_tuser;
        w.new_second     = s_axis_tdata[0];
        w.fresh_id       = s_axis_tdata[16:1];
        w.sender_address = s_axis_tdata[48:17];
        w.message_id     = s_axis_tdata[64:49];
        w.message_step   = s_axis_tdata[72:65];
        advance_session(w, want);
        replies_due.push_back(want);
      end
    end
    failures        <= miss_count;
    pending         <= replies_due.size();
    results_checked <= checked;
    dones_seen      <= done_count;
  end

endmodule

### tb/icmp_session_handshake_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_session_handshake_core_tb
// Drives client and listener handshakes through the core under a series of
// register settings, with random gaps and back-pressure; the checker predicts
// and compares every result word.
// ----------------------------------------------------------------------------
module icmp_session_handshake_core_tb;
  import icmp_sh_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic [1:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic [0:0]           m_axis_tuser;

  int unsigned failures;
  int unsigned pending;
  int unsigned results_checked;
  int unsigned dones_seen;

  logic        quiet = 1'b0;
  int unsigned in_rate = 0;
  int unsigned out_rate = 0;
  int unsigned hold_left = 0;
  int unsigned words_sent = 0;
  logic [31:0] cur_peer = '0;
  logic [15:0] sess_id = '0;
  logic [31:0] sess_addr = '0;

  always #2 clk = ~clk;

  icmp_session_handshake_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  icmp_session_handshake_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .failures        (failures),
    .pending         (pending),
    .results_checked (results_checked),
    .dones_seen      (dones_seen)
  );

  // back-pressure: randomly placed bursts with m_axis_tready held low
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && out_rate != 0 && $urandom_range(1, out_rate) == 1) begin
      hold_left <= $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic item_t word_of(input logic [1:0] op, input logic ns,
                                    input logic [15:0] fid, input logic [31:0] snd,
                                    input logic [15:0] mid, input logic [7:0] mstep);
    item_t w;
    w.op = op;
    w.new_second = ns;
    w.fresh_id = fid;
    w.sender_address = snd;
    w.message_id = mid;
    w.message_step = mstep;
    return w;
  endfunction

  function automatic item_t noise_word();
    return word_of(2'($urandom_range(1, 3)), 1'($urandom), 16'($urandom), $urandom,
                   16'($urandom), 8'($urandom));
  endfunction

  task automatic push_word(input item_t w);
    // now and then pick new idle rates; zero means a stretch with no gaps
    if ($urandom_range(0, 63) == 0) begin
      in_rate = $urandom_range(0, 3) * 3;
      out_rate <= $urandom_range(0, 3) * 3;
    end
    if (!quiet && in_rate != 0 && $urandom_range(1, in_rate) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, w.message_step, w.message_id, w.sender_address,
                     w.fresh_id, w.new_second};
    s_axis_tuser <= w.op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic mode, input logic [31:0] peer,
                           input logic [7:0] tmo, input logic [7:0] vlimit);
    cur_peer = peer;
    write_reg(CFG_LISTENER_MODE, {31'd0, mode});
    write_reg(CFG_PEER_ADDRESS, peer);
    write_reg(CFG_TIMEOUT_SECONDS, {24'd0, tmo});
    write_reg(CFG_VERIFY_LIMIT, {24'd0, vlimit});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic new_session();
    sess_id = 16'($urandom);
    sess_addr = $urandom;
  endtask

  // client side: service passes and verify replies from the peer, plus noise
  task automatic client_word(input bit deep);
    int unsigned r;
    item_t w;
    r = $urandom_range(0, 99);
    w = noise_word();
    if (r < (deep ? 50 : 45)) begin
      w.op = OP_SERVICE;
      w.fresh_id = sess_id;
      w.new_second = ($urandom_range(0, 7) == 0);
    end else if (r < (deep ? 96 : 88)) begin
      w.op = OP_VERIFY;
      w.sender_address = cur_peer;
      w.message_id = sess_id;
      if (deep || $urandom_range(0, 3) != 0) w.message_step = 8'hFF;
    end else if (r < (deep ? 98 : 94)) begin
      w.op = OP_VERIFY;
      w.sender_address = cur_peer;
      w.message_id = sess_id;
      if ($urandom_range(0, 1)) w.sender_address[$urandom_range(0, 31)] ^= 1'b1;
      else w.message_id[$urandom_range(0, 15)] ^= 1'b1;
    end
    push_word(w);
  endtask

  // listener side: establish messages from one remote and service passes, plus noise
  task automatic listener_word(input bit deep);
    int unsigned r;
    item_t w;
    r = $urandom_range(0, 99);
    w = noise_word();
    if (r < (deep ? 75 : 55)) begin
      w.op = OP_ESTABLISH;
      w.sender_address = sess_addr;
      w.message_id = sess_id;
      if (deep || $urandom_range(0, 3) != 0) w.message_step = 8'hFF;
    end else if (r < (deep ? 90 : 75)) begin
      w.op = OP_SERVICE;
      w.new_second = ($urandom_range(0, 3) == 0);
    end else if (r < 85) begin
      w.op = OP_ESTABLISH;
      w.sender_address = sess_addr;
      w.message_id = sess_id;
      if ($urandom_range(0, 1)) w.sender_address[$urandom_range(0, 31)] ^= 1'b1;
      else w.message_id[$urandom_range(0, 15)] ^= 1'b1;
    end
    push_word(w);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // client under reset settings
    push_word(word_of(OP_SERVICE, 1'b1, 16'hFFFF, 32'h0, 16'h0, 8'h0));
    push_word(word_of(OP_VERIFY, 1'b0, 16'h0, 32'h0, 16'hFFFF, 8'hFF));
    push_word(word_of(OP_SERVICE, 1'b0, 16'h0, 32'h0, 16'h0, 8'h0));
    push_word(word_of(OP_VERIFY, 1'b0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
    push_word(word_of(OP_VERIFY, 1'b0, 16'h0, 32'h0, 16'h0, 8'hFF));
    push_word(word_of(OP_ESTABLISH, 1'b0, 16'h0, 32'h0, 16'hFFFF, 8'hFF));
    push_word(word_of(OP_UNUSED, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
    push_word(word_of(OP_VERIFY, 1'b0, 16'h0, 32'h0, 16'hFFFF, 8'h0));
    // four idle seconds at an odd step: restart and a new id
    repeat (4) push_word(word_of(OP_SERVICE, 1'b1, 16'h1234, 32'h0, 16'h0, 8'h0));
    push_word(word_of(OP_VERIFY, 1'b0, 16'h0, 32'h0, 16'h1234, 8'hFF));

    // switch role with the session state kept
    drain();
    configure(1'b1, 32'hFFFF_FFFF, 8'd0, 8'd1);
    push_word(word_of(OP_SERVICE, 1'b0, 16'h0, 32'h0, 16'h0, 8'h0));
    push_word(word_of(OP_ESTABLISH, 1'b0, 16'h0, 32'h0, 16'h1234, 8'hFF));
    push_word(word_of(OP_SERVICE, 1'b1, 16'h0, 32'h0, 16'h0, 8'h0));
    push_word(word_of(OP_ESTABLISH, 1'b1, 16'h0, 32'hFFFF_FFFF, 16'h0, 8'h0));
    push_word(word_of(OP_VERIFY, 1'b0, 16'h0, 32'hFFFF_FFFF, 16'h0, 8'hFF));
    push_word(word_of(OP_ESTABLISH, 1'b0, 16'h0, 32'h0, 16'h0, 8'hFF));

    new_session();
    drain();
    configure(1'b0, 32'h0, 8'd3, 8'd11);
    repeat (200) client_word(1'b0);

    drain();
    configure(1'b1, $urandom, 8'd2, 8'd20);
    repeat (200) listener_word(1'b0);
    // force a restart so the next run begins from first contact
    repeat (4) push_word(word_of(OP_SERVICE, 1'b1, 16'($urandom), $urandom,
                                 16'($urandom), 8'($urandom)));

    // long listener run with no timeout: step saturates, then the seconds do
    drain();
    configure(1'b1, $urandom, 8'd255, 8'd251);
    push_word(word_of(OP_ESTABLISH, 1'b0, 16'($urandom), sess_addr, sess_id, 8'hFF));
    repeat (250) listener_word(1'b1);
    repeat (270) push_word(word_of(OP_SERVICE, 1'b1, 16'($urandom), $urandom,
                                   16'($urandom), 8'($urandom)));

    drain();
    configure(1'b1, $urandom, 8'd254, 8'd251);
    repeat (150) listener_word(1'b0);

    new_session();
    drain();
    configure(1'b0, 32'hFFFF_FFFF, 8'd0, 8'd1);
    repeat (150) client_word(1'b0);

    drain();
    configure(1'b0, $urandom, 8'd255, 8'd251);
    repeat (150) client_word(1'b1);

    new_session();
    drain();
    configure(1'b1, $urandom, 8'($urandom_range(1, 6)), 8'($urandom_range(1, 40)));
    repeat (150) listener_word(1'b0);

    drain();
    quiet <= 1'b1;
    configure(1'b0, $urandom, 8'($urandom_range(1, 8)), 8'($urandom_range(1, 30)));
    repeat (150) client_word(1'b0);

    drain();
    repeat (8) @(posedge clk);
    $display("%0d words sent over 9 register settings, both roles", words_sent);
    $display("%0d result words checked, %0d of them reporting a finished handshake",
             results_checked, dones_seen);
    if (failures == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
